// File: design/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Shared types and constants of the multi-slot alarm timer.
// ----------------------------------------------------------------------------
package mat_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam int OP_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int DELTA_W = 31;
    localparam int TIME_W  = 32;
    localparam int BILL_W  = 5;
    localparam int KIND_W  = 3;
    localparam int TPS_W   = 10;
    localparam int SLICE_W = 8;
    localparam int HK_W    = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_UPTIME  = 3'd1;
    localparam logic [OP_W-1:0] OP_GETTIME = 3'd2;
    localparam logic [OP_W-1:0] OP_SETTIME = 3'd3;
    localparam logic [OP_W-1:0] OP_ALARM   = 3'd4;
    localparam logic [OP_W-1:0] OP_SYNC    = 3'd5;

    localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESCHED = 3'd4;

    localparam logic [HK_W-1:0] HK_SIGNAL   = 2'd0;
    localparam logic [HK_W-1:0] HK_SYNC     = 2'd2;
    localparam logic [HK_W-1:0] HK_RESERVED = 2'd3;

    localparam logic [TPS_W-1:0]   TPS_RST   = 10'd60;
    localparam logic [SLICE_W-1:0] SLICE_RST = 8'd6;
    localparam logic [TIME_W-1:0]  NONE_PENDING = 32'hFFFF_FFFF;

    localparam logic REG_TPS   = 1'b0;
    localparam logic REG_SLICE = 1'b1;

    typedef struct packed {
        logic load;
        logic tick;
        logic scan_start;
        logic fire_en;
        logic rd_slot;
        logic eval;
        logic set_earliest;
        logic div_start;
        logic div_arm;
        logic set_boot;
        logic arm_cap;
        logic arm_wr;
        logic push_pend;
        logic pend_last;
        logic push_resched;
        logic push_reply;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic in_range;
        logic due;
        logic old_nz;
        logic resched;
        logic pend_vld;
        logic out_free;
        logic hit;
        logic scan_last;
        logic div_busy;
    } dp_sts_t;

endpackage

// File: design/mat_ram.sv
// ----------------------------------------------------------------------------
// mat_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/mat_ctrl.sv
// ----------------------------------------------------------------------------
// mat_ctrl
// Sequencer of the alarm timer: steps one request through tick, scan,
// divide, arm and reply phases and drives the datapath commands.
// ----------------------------------------------------------------------------
module mat_ctrl import mat_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_TICK  = 4'd1;
    localparam logic [3:0] ST_TCHK  = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SEV   = 4'd4;
    localparam logic [3:0] ST_SEND  = 4'd5;
    localparam logic [3:0] ST_FIN1  = 4'd6;
    localparam logic [3:0] ST_FIN2  = 4'd7;
    localparam logic [3:0] ST_DIVS  = 4'd8;
    localparam logic [3:0] ST_DIVW  = 4'd9;
    localparam logic [3:0] ST_ARD   = 4'd10;
    localparam logic [3:0] ST_AEV   = 4'd11;
    localparam logic [3:0] ST_ADIV  = 4'd12;
    localparam logic [3:0] ST_AWR   = 4'd13;
    localparam logic [3:0] ST_REPLY = 4'd14;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                unique case (sts.op)
                    OP_TICK: begin
                        cmd.tick   = 1'b1;
                        state_next = ST_TCHK;
                    end
                    OP_UPTIME:              state_next = ST_REPLY;
                    OP_GETTIME, OP_SETTIME: state_next = ST_DIVS;
                    OP_ALARM, OP_SYNC:      state_next = ST_ARD;
                    default:                state_next = ST_IDLE;
                endcase
            end
            ST_TCHK: begin
                if (sts.due) begin
                    cmd.scan_start = 1'b1;
                    cmd.fire_en    = 1'b1;
                    state_next     = ST_SRD;
                end else begin
                    state_next = ST_FIN1;
                end
            end
            ST_SRD: state_next = ST_SEV;
            ST_SEV: begin
                if (!(sts.hit && sts.pend_vld && !sts.out_free)) begin
                    cmd.eval   = 1'b1;
                    state_next = sts.scan_last ? ST_SEND : ST_SRD;
                end
            end
            ST_SEND: begin
                cmd.set_earliest = 1'b1;
                state_next       = (sts.op == OP_TICK) ? ST_FIN1 : ST_REPLY;
            end
            ST_FIN1: begin
                if (sts.pend_vld) begin
                    if (sts.out_free) begin
                        cmd.push_pend = 1'b1;
                        cmd.pend_last = !sts.resched;
                        state_next    = sts.resched ? ST_FIN2 : ST_IDLE;
                    end
                end else begin
                    state_next = sts.resched ? ST_FIN2 : ST_IDLE;
                end
            end
            ST_FIN2: begin
                if (sts.out_free) begin
                    cmd.push_resched = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW: begin
                if (!sts.div_busy) begin
                    cmd.set_boot = (sts.op == OP_SETTIME);
                    state_next   = (sts.op == OP_ALARM || sts.op == OP_SYNC) ? ST_AWR
                                                                            : ST_REPLY;
                end
            end
            ST_ARD: begin
                cmd.rd_slot = 1'b1;
                state_next  = sts.in_range ? ST_AEV : ST_REPLY;
            end
            ST_AEV: begin
                cmd.arm_cap = 1'b1;
                state_next  = ST_ADIV;
            end
            ST_ADIV: begin
                if (sts.old_nz) begin
                    cmd.div_start = 1'b1;
                    cmd.div_arm   = 1'b1;
                    state_next    = ST_DIVW;
                end else begin
                    state_next = ST_AWR;
                end
            end
            ST_AWR: begin
                cmd.arm_wr     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SRD;
            end
            ST_REPLY: begin
                if (sts.out_free) begin
                    cmd.push_reply = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: design/mat_dp.sv
// ----------------------------------------------------------------------------
// mat_dp
// Datapath of the alarm timer: counters, deadline store, slot scan,
// serial divider, pending fired result and the output register.
// ----------------------------------------------------------------------------
module mat_dp import mat_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [OP_W-1:0]     in_op,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [DELTA_W-1:0]  in_delta,
    input  logic [TIME_W-1:0]   in_time,
    input  logic                in_cb,
    input  logic [BILL_W-1:0]   in_billed,
    input  logic [TPS_W-1:0]    cfg_tps,
    input  logic [SLICE_W-1:0]  cfg_slice,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   out_kind,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [TIME_W-1:0]   out_value,
    output logic                out_last
);

    localparam int AW = $clog2(NUM_SLOTS);
    localparam int RW = HK_W + TIME_W;
    localparam int CW = $clog2(TIME_W + 1);

    logic [OP_W-1:0]    op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               cb_reg;
    logic [BILL_W-1:0]  billed_reg;

    logic [TIME_W-1:0]  uptime_reg, boot_reg, earliest_reg, min_reg, old_d_reg;
    logic [SLICE_W-1:0] slice_reg;
    logic [BILL_W-1:0]  prev_reg;
    logic               resched_reg, fire_en_reg, rvld_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [AW-1:0]      idx_reg;
    logic               pend_vld_reg;
    logic [KIND_W-1:0]  pend_kind_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic [TPS_W-1:0]   rem_reg;
    logic [TIME_W-1:0]  quot_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;

    logic [AW-1:0]      slot_a, raddr;
    logic [RW-1:0]      rdata, wdata;
    logic [TIME_W-1:0]  rd_d, new_d, reply_val;
    logic [HK_W-1:0]    rd_k, hk_new, hk_fire;
    logic [KIND_W-1:0]  fire_kind;
    logic               in_range, hit, push;
    logic [SLICE_W-1:0] slice_next;
    logic [TPS_W-1:0]   dvsr;
    logic [TPS_W:0]     rem_sh, rem_diff;

    assign slot_a   = AW'(slot_reg);
    assign raddr    = cmd.rd_slot ? slot_a : idx_reg;
    assign in_range = 32'(slot_reg) < 32'(NUM_SLOTS);
    assign hk_new   = (op_reg == OP_SYNC) ? HK_SYNC : {1'b0, cb_reg};
    assign new_d    = (delta_reg == '0) ? '0 : uptime_reg + {1'b0, delta_reg};
    assign wdata    = {hk_new, new_d};

    mat_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (cmd.arm_wr),
        .waddr (slot_a),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_d      = rvld_reg ? rdata[TIME_W-1:0] : '0;
    assign rd_k      = rvld_reg ? rdata[RW-1:TIME_W] : HK_SIGNAL;
    assign hk_fire   = (rd_k == HK_RESERVED) ? HK_SYNC : rd_k;
    assign fire_kind = {1'b0, hk_fire} + 3'd1;
    assign hit       = fire_en_reg && (rd_d != '0) && (rd_d <= uptime_reg);
    assign slice_next = slice_reg - 8'd1;

    assign dvsr     = (cfg_tps == '0) ? 10'd1 : cfg_tps;
    assign rem_sh   = {rem_reg, quot_reg[TIME_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr};

    always_comb begin
        unique case (op_reg)
            OP_UPTIME:         reply_val = uptime_reg;
            OP_GETTIME:        reply_val = boot_reg + quot_reg;
            OP_ALARM, OP_SYNC: reply_val = (in_range && old_d_reg != '0) ? quot_reg : '0;
            default:           reply_val = '0;
        endcase
    end

    assign sts.op        = op_reg;
    assign sts.in_range  = in_range;
    assign sts.due       = earliest_reg <= uptime_reg;
    assign sts.old_nz    = old_d_reg != '0;
    assign sts.resched   = resched_reg;
    assign sts.pend_vld  = pend_vld_reg;
    assign sts.out_free  = !out_valid || out_ready;
    assign sts.hit       = hit;
    assign sts.scan_last = idx_reg == AW'(NUM_SLOTS - 1);
    assign sts.div_busy  = busy_reg;

    assign push = (cmd.eval && hit && pend_vld_reg) || cmd.push_pend
                  || cmd.push_resched || cmd.push_reply;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_op;
            slot_reg   <= in_slot;
            delta_reg  <= in_delta;
            time_reg   <= in_time;
            cb_reg     <= in_cb;
            billed_reg <= in_billed;
        end
        rvld_reg <= valid_reg[raddr];
        if (cmd.scan_start) begin
            idx_reg <= '0;
            min_reg <= NONE_PENDING;
        end else if (cmd.eval) begin
            idx_reg <= idx_reg + 1'b1;
            if (!hit && rd_d != '0 && rd_d < min_reg) begin
                min_reg <= rd_d;
            end
        end
        if (cmd.eval && hit) begin
            pend_kind_reg <= fire_kind;
            pend_slot_reg <= SLOT_W'(idx_reg);
        end
        if (cmd.arm_cap) begin
            old_d_reg <= rd_d;
        end
        if (cmd.div_start) begin
            quot_reg <= cmd.div_arm ? old_d_reg - uptime_reg : uptime_reg;
            rem_reg  <= '0;
            cnt_reg  <= CW'(TIME_W);
        end else if (busy_reg) begin
            if (!rem_diff[TPS_W]) begin
                rem_reg  <= rem_diff[TPS_W-1:0];
                quot_reg <= {quot_reg[TIME_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[TPS_W-1:0];
                quot_reg <= {quot_reg[TIME_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (push) begin
            priority if (cmd.push_reply) begin
                out_kind  <= KIND_REPLY;
                out_slot  <= '0;
                out_value <= reply_val;
                out_last  <= 1'b1;
            end else if (cmd.push_resched) begin
                out_kind  <= KIND_RESCHED;
                out_slot  <= '0;
                out_value <= '0;
                out_last  <= 1'b1;
            end else begin
                out_kind  <= pend_kind_reg;
                out_slot  <= pend_slot_reg;
                out_value <= '0;
                out_last  <= cmd.push_pend && cmd.pend_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uptime_reg   <= '0;
            boot_reg     <= '0;
            earliest_reg <= NONE_PENDING;
            slice_reg    <= SLICE_RST;
            prev_reg     <= '0;
            resched_reg  <= 1'b0;
            fire_en_reg  <= 1'b0;
            valid_reg    <= '0;
            pend_vld_reg <= 1'b0;
            busy_reg     <= 1'b0;
            out_valid    <= 1'b0;
        end else begin
            if (cmd.tick) begin
                uptime_reg <= uptime_reg + 32'd1;
                if (slice_next == '0) begin
                    resched_reg <= (billed_reg == prev_reg);
                    slice_reg   <= cfg_slice;
                    prev_reg    <= billed_reg;
                end else begin
                    resched_reg <= 1'b0;
                    slice_reg   <= slice_next;
                end
            end
            if (cmd.set_boot) begin
                boot_reg <= time_reg - quot_reg;
            end
            if (cmd.set_earliest) begin
                earliest_reg <= min_reg;
            end
            if (cmd.scan_start) begin
                fire_en_reg <= cmd.fire_en;
            end
            if (cmd.arm_wr) begin
                valid_reg[slot_a] <= 1'b1;
            end
            if (cmd.eval && hit) begin
                valid_reg[idx_reg] <= 1'b0;
                pend_vld_reg       <= 1'b1;
            end else if (cmd.push_pend) begin
                pend_vld_reg <= 1'b0;
            end
            if (cmd.div_start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
            if (push) begin
                out_valid <= 1'b1;
            end else if (out_ready) begin
                out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: design/multi_slot_alarm_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_alarm_timer
// Tick counter with per-slot alarm deadlines and a scheduling time slice.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per beat: s_tuser is the opcode, s_tdata the
//   operands. m_* returns results: m_tuser is the result kind, m_tlast marks
//   the final result of a request. Registers ticks_per_second (0x0) and
//   slice_ticks (0x4) are written over the APB port; the user must write
//   them only while the block is idle, which the block does not enforce.
//   Requests are taken one at a time. A tick with no due alarm skips the
//   scan; a tick with due alarms or an arm request for a slot in range
//   scans every slot of the deadline RAM, one RAM read per slot. Time
//   reads, time set and the seconds left on an arm use a one-bit-per-cycle
//   divider. A result waits in the output register while the next request
//   is accepted; a stalled receiver holds the scan only when a second fired
//   result is ready. Reset clears the counters, all alarms and the output;
//   no clearing pass runs, slot valid bits clear at once.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer import mat_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // op
    input  logic [79:0] s_tdata,   // slot, delay, wall_secs, use_callback, billed_proc
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // kind
    output logic [39:0] m_tdata,   // fired_slot, value
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TPS_W-1:0]   tps_reg;
    logic [SLICE_W-1:0] slice_reg;
    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic [SLOT_W-1:0]  out_slot;
    logic [TIME_W-1:0]  out_value;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLICE) ? {24'd0, slice_reg} : {22'd0, tps_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg   <= TPS_RST;
            slice_reg <= SLICE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_TPS:   tps_reg   <= pwdata[TPS_W-1:0];
                REG_SLICE: slice_reg <= pwdata[SLICE_W-1:0];
                default:   tps_reg   <= tps_reg;
            endcase
        end
    end

    mat_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mat_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_slot   (s_tdata[4:0]),
        .in_delta  (s_tdata[35:5]),
        .in_time   (s_tdata[67:36]),
        .in_cb     (s_tdata[68]),
        .in_billed (s_tdata[73:69]),
        .cfg_tps   (tps_reg),
        .cfg_slice (slice_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_slot  (out_slot),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'd0, out_value, out_slot};

endmodule

// File: design/mat_chk.sv
// ----------------------------------------------------------------------------
// mat_chk
// Port-level checks of the alarm timer result stream.
// ----------------------------------------------------------------------------
module mat_chk import mat_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [2:0]  m_tuser,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REPLY || m_tuser == KIND_RESCHED) |-> m_tlast)
        else $error("reply or reschedule not final");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_REPLY |-> m_tdata[36:5] == 32'd0)
        else $error("nonzero value on alarm result");

endmodule

bind multi_slot_alarm_timer mat_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
